### hdl/gcqc_pkg.sv
// Shared types, register codes and constants of the grid cell quad classifier.
`timescale 1ns / 1ps
`default_nettype none

package gcqc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COUNT_WIDTH_DEF = 24;

   localparam int SIZE_LIMIT_W   = 31;
   localparam int POLE_RATIO_W   = 16;
   localparam int ASPECT_LIMIT_W = 16;
   localparam int CSR_DATA_W     = 31;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [SIZE_LIMIT_W-1:0]   SIZE_LIMIT_RST   = SIZE_LIMIT_W'(64000000);
   localparam logic [POLE_RATIO_W-1:0]   POLE_RATIO_RST   = POLE_RATIO_W'(1000);
   localparam logic [ASPECT_LIMIT_W-1:0] ASPECT_LIMIT_RST = ASPECT_LIMIT_W'(100);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SIZE_LIMIT   = 2'd0,
      REG_POLE_RATIO   = 2'd1,
      REG_ASPECT_LIMIT = 2'd2
   } cfg_index_type;

   typedef struct packed {
      logic [SIZE_LIMIT_W-1:0]   size_limit;
      logic [POLE_RATIO_W-1:0]   pole_ratio;
      logic [ASPECT_LIMIT_W-1:0] aspect_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      CLS_CW_CONVEX  = 3'd0,
      CLS_CCW_CONVEX = 3'd1,
      CLS_INVALID    = 3'd2,
      CLS_NOT_CONVEX = 3'd3,
      CLS_HUGE       = 3'd4,
      CLS_OBLONG     = 3'd5,
      CLS_POLE       = 3'd6
   } cell_class_type;

   typedef struct packed {
      cell_class_type cls;
      logic           last;
   } cls_item_type;

endpackage

`default_nettype wire

### hdl/gcqc_geom.sv
// Geometry stage: edge vectors, opposite x spans and bounding box size of a cell.
`timescale 1ns / 1ps
`default_nettype none

module gcqc_geom
   import gcqc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [8*COORD_WIDTH-1:0]      coords,
   input  wire logic                          nan_in,
   input  wire logic                          last_in,
   output logic signed [COORD_WIDTH:0]        edge_x [4],
   output logic signed [COORD_WIDTH:0]        edge_y [4],
   output logic        [COORD_WIDTH:0]        span1,
   output logic        [COORD_WIDTH:0]        span2,
   output logic        [COORD_WIDTH-1:0]      box_w,
   output logic        [COORD_WIDTH-1:0]      box_h,
   output logic                               nan_out,
   output logic                               last_out
);

   localparam int CW = COORD_WIDTH;

   logic signed [CW:0]   px [4];
   logic signed [CW:0]   py [4];
   logic signed [CW:0]   ex_in [4];
   logic signed [CW:0]   ey_in [4];
   logic        [CW:0]   span1_in, span2_in;
   logic signed [CW:0]   max_x01, max_x23, min_x01, min_x23;
   logic signed [CW:0]   max_y01, max_y23, min_y01, min_y23;
   logic signed [CW:0]   max_x, min_x, max_y, min_y;
   logic signed [CW:0]   w_diff, h_diff;

   logic signed [CW:0]   ex_ff [4];
   logic signed [CW:0]   ey_ff [4];
   logic        [CW:0]   span1_ff, span2_ff;
   logic        [CW-1:0] w_ff, h_ff;
   logic                 nan_ff, last_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px[k] = $signed({coords[(2*k+1)*CW-1], coords[(2*k)*CW +: CW]});
         py[k] = $signed({coords[(2*k+2)*CW-1], coords[(2*k+1)*CW +: CW]});
      end
      // Edge k runs from corner k to the next corner around the ring.
      for (int k = 0; k < 4; k++) begin
         ex_in[k] = px[(k + 1) & 3] - px[k];
         ey_in[k] = py[(k + 1) & 3] - py[k];
      end
      span1_in = (px[0] >= px[3]) ? unsigned'(px[0] - px[3]) : unsigned'(px[3] - px[0]);
      span2_in = (px[2] >= px[1]) ? unsigned'(px[2] - px[1]) : unsigned'(px[1] - px[2]);

      max_x01 = (px[0] > px[1]) ? px[0] : px[1];
      max_x23 = (px[2] > px[3]) ? px[2] : px[3];
      min_x01 = (px[0] < px[1]) ? px[0] : px[1];
      min_x23 = (px[2] < px[3]) ? px[2] : px[3];
      max_y01 = (py[0] > py[1]) ? py[0] : py[1];
      max_y23 = (py[2] > py[3]) ? py[2] : py[3];
      min_y01 = (py[0] < py[1]) ? py[0] : py[1];
      min_y23 = (py[2] < py[3]) ? py[2] : py[3];
      max_x   = (max_x01 > max_x23) ? max_x01 : max_x23;
      min_x   = (min_x01 < min_x23) ? min_x01 : min_x23;
      max_y   = (max_y01 > max_y23) ? max_y01 : max_y23;
      min_y   = (min_y01 < min_y23) ? min_y01 : min_y23;
      w_diff  = max_x - min_x;
      h_diff  = max_y - min_y;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 4; k++) begin
            ex_ff[k] <= ex_in[k];
            ey_ff[k] <= ey_in[k];
         end
         span1_ff <= span1_in;
         span2_ff <= span2_in;
         w_ff     <= w_diff[CW-1:0];
         h_ff     <= h_diff[CW-1:0];
         nan_ff   <= nan_in;
         last_ff  <= last_in;
      end
   end

   assign edge_x   = ex_ff;
   assign edge_y   = ey_ff;
   assign span1    = span1_ff;
   assign span2    = span2_ff;
   assign box_w    = w_ff;
   assign box_h    = h_ff;
   assign nan_out  = nan_ff;
   assign last_out = last_ff;

endmodule

`default_nettype wire

### hdl/gcqc_prod.sv
// Product stage: edge cross products and the pole and aspect scaled spans.
`timescale 1ns / 1ps
`default_nettype none

module gcqc_prod
   import gcqc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire cfg_type                             cfg,
   input  wire logic signed [COORD_WIDTH:0]         edge_x [4],
   input  wire logic signed [COORD_WIDTH:0]         edge_y [4],
   input  wire logic        [COORD_WIDTH:0]         span1_in,
   input  wire logic        [COORD_WIDTH:0]         span2_in,
   input  wire logic        [COORD_WIDTH-1:0]       box_w_in,
   input  wire logic        [COORD_WIDTH-1:0]       box_h_in,
   input  wire logic                                nan_in,
   input  wire logic                                last_in,
   output logic signed [2*COORD_WIDTH+1:0]          cross_pq [4],
   output logic signed [2*COORD_WIDTH+1:0]          cross_rs [4],
   output logic        [COORD_WIDTH+POLE_RATIO_W:0] pole1_prod,
   output logic        [COORD_WIDTH+POLE_RATIO_W:0] pole2_prod,
   output logic        [COORD_WIDTH+ASPECT_LIMIT_W-1:0] h_scaled,
   output logic        [COORD_WIDTH+ASPECT_LIMIT_W-1:0] w_scaled,
   output logic        [COORD_WIDTH:0]              span1_out,
   output logic        [COORD_WIDTH:0]              span2_out,
   output logic        [COORD_WIDTH-1:0]            box_w_out,
   output logic        [COORD_WIDTH-1:0]            box_h_out,
   output logic                                     nan_out,
   output logic                                     last_out
);

   localparam int CW = COORD_WIDTH;
   localparam int XW = 2 * CW + 2;
   localparam int PW = CW + 1 + POLE_RATIO_W;
   localparam int AW = CW + ASPECT_LIMIT_W;

   logic signed [XW-1:0] pq_ff [4];
   logic signed [XW-1:0] rs_ff [4];
   logic        [PW-1:0] pole1_ff, pole2_ff;
   logic        [AW-1:0] hs_ff, ws_ff;
   logic        [CW:0]   span1_ff, span2_ff;
   logic        [CW-1:0] w_ff, h_ff;
   logic                 nan_ff, last_ff;

   // Corner k+1 turns by the cross product of edge k and edge k+1.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 4; k++) begin
            pq_ff[k] <= XW'(edge_x[k]) * XW'(edge_y[(k + 1) & 3]);
            rs_ff[k] <= XW'(edge_y[k]) * XW'(edge_x[(k + 1) & 3]);
         end
         pole1_ff <= PW'(span1_in) * PW'(cfg.pole_ratio);
         pole2_ff <= PW'(span2_in) * PW'(cfg.pole_ratio);
         hs_ff    <= AW'(box_h_in) * AW'(cfg.aspect_limit);
         ws_ff    <= AW'(box_w_in) * AW'(cfg.aspect_limit);
         span1_ff <= span1_in;
         span2_ff <= span2_in;
         w_ff     <= box_w_in;
         h_ff     <= box_h_in;
         nan_ff   <= nan_in;
         last_ff  <= last_in;
      end
   end

   assign cross_pq   = pq_ff;
   assign cross_rs   = rs_ff;
   assign pole1_prod = pole1_ff;
   assign pole2_prod = pole2_ff;
   assign h_scaled   = hs_ff;
   assign w_scaled   = ws_ff;
   assign span1_out  = span1_ff;
   assign span2_out  = span2_ff;
   assign box_w_out  = w_ff;
   assign box_h_out  = h_ff;
   assign nan_out    = nan_ff;
   assign last_out   = last_ff;

endmodule

`default_nettype wire

### hdl/gcqc_class.sv
// Classification stage: compares the products and picks the cell class by priority.
`timescale 1ns / 1ps
`default_nettype none

module gcqc_class
   import gcqc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire cfg_type                             cfg,
   input  wire logic signed [2*COORD_WIDTH+1:0]     cross_pq [4],
   input  wire logic signed [2*COORD_WIDTH+1:0]     cross_rs [4],
   input  wire logic        [COORD_WIDTH+POLE_RATIO_W:0] pole1_prod,
   input  wire logic        [COORD_WIDTH+POLE_RATIO_W:0] pole2_prod,
   input  wire logic        [COORD_WIDTH+ASPECT_LIMIT_W-1:0] h_scaled,
   input  wire logic        [COORD_WIDTH+ASPECT_LIMIT_W-1:0] w_scaled,
   input  wire logic        [COORD_WIDTH:0]         span1,
   input  wire logic        [COORD_WIDTH:0]         span2,
   input  wire logic        [COORD_WIDTH-1:0]       box_w,
   input  wire logic        [COORD_WIDTH-1:0]       box_h,
   input  wire logic                                nan_in,
   input  wire logic                                last_in,
   output cls_item_type                             item
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + 1 + POLE_RATIO_W;
   localparam int AW = CW + ASPECT_LIMIT_W;
   localparam int SW = (CW > SIZE_LIMIT_W) ? CW : SIZE_LIMIT_W;

   logic [3:0]     turn_le, turn_ge;
   logic           is_pole, is_empty, is_huge, is_oblong;
   cell_class_type cls_in;
   cls_item_type   item_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         turn_le[k] = (cross_pq[k] <= cross_rs[k]);
         turn_ge[k] = (cross_pq[k] >= cross_rs[k]);
      end
      is_pole   = (PW'(span2) > pole1_prod) || (PW'(span1) > pole2_prod);
      is_empty  = (box_w == '0) || (box_h == '0);
      is_huge   = (SW'(box_w) >= SW'(cfg.size_limit)) ||
                  (SW'(box_h) >= SW'(cfg.size_limit));
      is_oblong = (h_scaled < AW'(box_w)) || (AW'(box_h) > w_scaled);

      if (nan_in) begin
         cls_in = CLS_INVALID;
      end else if (is_pole) begin
         cls_in = CLS_POLE;
      end else if (is_empty) begin
         cls_in = CLS_INVALID;
      end else if (is_huge) begin
         cls_in = CLS_HUGE;
      end else if (is_oblong) begin
         cls_in = CLS_OBLONG;
      end else if (&turn_le) begin
         // Clockwise wins when every corner is straight.
         cls_in = CLS_CW_CONVEX;
      end else if (&turn_ge) begin
         cls_in = CLS_CCW_CONVEX;
      end else begin
         cls_in = CLS_NOT_CONVEX;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.cls  <= cls_in;
         item_ff.last <= last_in;
      end
   end

   assign item = item_ff;

endmodule

`default_nettype wire

### hdl/gcqc_tally.sv
// Tally stage: saturating orientation counts, flip verdict and the result register.
`timescale 1ns / 1ps
`default_nettype none

module gcqc_tally
   import gcqc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire cls_item_type item,
   output cell_class_type    cls,
   output logic              last,
   output logic              flip
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] cw_ff, ccw_ff, cw_in, ccw_in;
   logic [COUNT_WIDTH-1:0] cw_new, ccw_new;
   logic                   flip_in;
   cell_class_type         cls_ff;
   logic                   last_ff, flip_ff;

   always_comb begin
      cw_new  = cw_ff;
      ccw_new = ccw_ff;
      if (item.cls == CLS_CW_CONVEX && cw_ff != COUNT_MAX) begin
         cw_new = cw_ff + 1'b1;
      end else if (item.cls == CLS_CCW_CONVEX && ccw_ff != COUNT_MAX) begin
         ccw_new = ccw_ff + 1'b1;
      end
      // The verdict counts the last cell too, then both counts start over.
      if (item.last) begin
         flip_in = ({1'b0, ccw_new} > {cw_new, 1'b0});
         cw_in   = '0;
         ccw_in  = '0;
      end else begin
         flip_in = 1'b0;
         cw_in   = cw_new;
         ccw_in  = ccw_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff  <= '0;
         ccw_ff <= '0;
      end else if (load) begin
         cw_ff  <= cw_in;
         ccw_ff <= ccw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cls_ff  <= item.cls;
         last_ff <= item.last;
         flip_ff <= flip_in;
      end
   end

   assign cls  = cls_ff;
   assign last = last_ff;
   assign flip = flip_ff;

endmodule

`default_nettype wire

### hdl/grid_cell_quad_classifier.sv
// Top level of the grid cell quad classifier: handshake, pipeline control and registers.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one projected grid cell per transfer on the req_ channel and
// returns exactly one result per cell on the rsp_ channel, in order.
// A request carries the four corners a, b, c, d in ring order in req_tdata,
// the missing coordinate flag in req_tuser and the last cell of the grid in
// req_tlast. The result carries the class and its flags in rsp_tdata and
// echoes the last cell marker in rsp_tlast; on that result the flip verdict
// (counterclockwise cells more than twice the clockwise ones) is valid.
// The datapath is five register stages: input, geometry (edges, spans,
// bounding box), products, classification, and the tally with the result
// register. A new cell is taken every cycle while the receiver keeps up, and
// the single product stage forms all twelve products at once.
// Each stage moves on when its successor is empty or moving, so bubbles are
// squeezed out and requests keep flowing into free stages while the receiver
// stalls a result; once all stages hold cells, req_tready drops.
// Reset empties the pipeline, clears both orientation counts and loads the
// default size limit, pole ratio and aspect limit. The csr_ port writes a
// register and must be used only while the block is idle, which it does not check.

module grid_cell_quad_classifier
   import gcqc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel.
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
   // corner_c_x, corner_c_y, corner_d_x, corner_d_y
   input  wire logic [8*COORD_WIDTH-1:0] req_tdata,
   // not_a_number
   input  wire logic [0:0]               req_tuser,
   input  wire logic                     req_tlast,
   // Result channel.
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // cell_class[2:0], cell_valid, cell_clockwise, flip_verdict, two zero bits
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast,
   // Register write port.
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = COORD_WIDTH;

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_limit   <= SIZE_LIMIT_RST;
         cfg_ff.pole_ratio   <= POLE_RATIO_RST;
         cfg_ff.aspect_limit <= ASPECT_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (cfg_index_type'(csr_index))
            REG_SIZE_LIMIT:   cfg_ff.size_limit   <= csr_wdata[SIZE_LIMIT_W-1:0];
            REG_POLE_RATIO:   cfg_ff.pole_ratio   <= csr_wdata[POLE_RATIO_W-1:0];
            REG_ASPECT_LIMIT: cfg_ff.aspect_limit <= csr_wdata[ASPECT_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits and the advance chain from the result side backwards.
   logic in_v_ff, geo_v_ff, prod_v_ff, cls_v_ff, out_v_ff;
   logic adv_in, adv_geo, adv_prod, adv_cls, adv_out;

   assign adv_out  = !out_v_ff  || rsp_tready;
   assign adv_cls  = !cls_v_ff  || adv_out;
   assign adv_prod = !prod_v_ff || adv_cls;
   assign adv_geo  = !geo_v_ff  || adv_prod;
   assign adv_in   = !in_v_ff   || adv_geo;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         geo_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         cls_v_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (adv_in)   in_v_ff   <= req_tvalid;
         if (adv_geo)  geo_v_ff  <= in_v_ff;
         if (adv_prod) prod_v_ff <= geo_v_ff;
         if (adv_cls)  cls_v_ff  <= prod_v_ff;
         if (adv_out)  out_v_ff  <= cls_v_ff;
      end
   end

   // Input register.
   logic [8*CW-1:0] coords_ff;
   logic            nan_ff, last_ff;

   always_ff @(posedge clock) begin
      if (adv_in && req_tvalid) begin
         coords_ff <= req_tdata;
         nan_ff    <= req_tuser[0];
         last_ff   <= req_tlast;
      end
   end

   // Geometry stage.
   logic signed [CW:0]   geo_ex [4];
   logic signed [CW:0]   geo_ey [4];
   logic        [CW:0]   geo_span1, geo_span2;
   logic        [CW-1:0] geo_w, geo_h;
   logic                 geo_nan, geo_last;

   gcqc_geom #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_geom (
      .clock    (clock),
      .load     (adv_geo && in_v_ff),
      .coords   (coords_ff),
      .nan_in   (nan_ff),
      .last_in  (last_ff),
      .edge_x   (geo_ex),
      .edge_y   (geo_ey),
      .span1    (geo_span1),
      .span2    (geo_span2),
      .box_w    (geo_w),
      .box_h    (geo_h),
      .nan_out  (geo_nan),
      .last_out (geo_last)
   );

   // Product stage.
   logic signed [2*CW+1:0]              prod_pq [4];
   logic signed [2*CW+1:0]              prod_rs [4];
   logic        [CW+POLE_RATIO_W:0]     prod_pole1, prod_pole2;
   logic        [CW+ASPECT_LIMIT_W-1:0] prod_hs, prod_ws;
   logic        [CW:0]                  prod_span1, prod_span2;
   logic        [CW-1:0]                prod_w, prod_h;
   logic                                prod_nan, prod_last;

   gcqc_prod #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prod (
      .clock      (clock),
      .load       (adv_prod && geo_v_ff),
      .cfg        (cfg_ff),
      .edge_x     (geo_ex),
      .edge_y     (geo_ey),
      .span1_in   (geo_span1),
      .span2_in   (geo_span2),
      .box_w_in   (geo_w),
      .box_h_in   (geo_h),
      .nan_in     (geo_nan),
      .last_in    (geo_last),
      .cross_pq   (prod_pq),
      .cross_rs   (prod_rs),
      .pole1_prod (prod_pole1),
      .pole2_prod (prod_pole2),
      .h_scaled   (prod_hs),
      .w_scaled   (prod_ws),
      .span1_out  (prod_span1),
      .span2_out  (prod_span2),
      .box_w_out  (prod_w),
      .box_h_out  (prod_h),
      .nan_out    (prod_nan),
      .last_out   (prod_last)
   );

   // Classification stage.
   cls_item_type cls_item;

   gcqc_class #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_class (
      .clock      (clock),
      .load       (adv_cls && prod_v_ff),
      .cfg        (cfg_ff),
      .cross_pq   (prod_pq),
      .cross_rs   (prod_rs),
      .pole1_prod (prod_pole1),
      .pole2_prod (prod_pole2),
      .h_scaled   (prod_hs),
      .w_scaled   (prod_ws),
      .span1      (prod_span1),
      .span2      (prod_span2),
      .box_w      (prod_w),
      .box_h      (prod_h),
      .nan_in     (prod_nan),
      .last_in    (prod_last),
      .item       (cls_item)
   );

   // Tally stage and result register. The counts move only on a real cell.
   cell_class_type out_cls;
   logic           out_last, out_flip;
   logic           out_valid_cell, out_clockwise;

   gcqc_tally #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tally (
      .clock (clock),
      .reset (reset),
      .load  (adv_out && cls_v_ff),
      .item  (cls_item),
      .cls   (out_cls),
      .last  (out_last),
      .flip  (out_flip)
   );

   assign out_valid_cell = (out_cls == CLS_CW_CONVEX) || (out_cls == CLS_CCW_CONVEX);
   assign out_clockwise  = (out_cls == CLS_CW_CONVEX);

   assign req_tready = adv_in;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_flip, out_clockwise, out_valid_cell, out_cls};
   assign rsp_tlast  = out_last;

endmodule

`default_nettype wire
